### design/integer_to_ascii_radix_assert.svh
// Assertion macros shared by the integer-to-ASCII converter RTL.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, skipped while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, skipped while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/itoa_pkg.sv
// Constants, types and the digit table of the integer-to-ASCII converter.
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;

    localparam int DEC_DIGITS = (VALUE_WIDTH * 301) / 1000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;

    localparam int DEC_BITS = DEC_DIGITS * 4;
    localparam int HEX_BITS = HEX_DIGITS * 4;
    localparam int OCT_BITS = OCT_DIGITS * 3;

    localparam int SR_W = (DEC_BITS >= HEX_BITS)
                        ? ((DEC_BITS >= OCT_BITS) ? DEC_BITS : OCT_BITS)
                        : ((HEX_BITS >= OCT_BITS) ? HEX_BITS : OCT_BITS);

    localparam int MAX_DIGITS = (DEC_DIGITS >= HEX_DIGITS)
                              ? ((DEC_DIGITS >= OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS)
                              : ((HEX_DIGITS >= OCT_DIGITS) ? HEX_DIGITS : OCT_DIGITS);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_WIDTH + 1);
    localparam int CHAR_W = 7;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    localparam logic [CHAR_W-1:0] DIGIT_SET [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

### design/integer_to_ascii_radix.sv
// Integer-to-ASCII converter: decimal, lower-case hexadecimal or octal digits.
//
// Input request (s_*): one number per request. s_tdata carries the value; s_tuser
// carries the signed flag and the radix code. s_tready is high only while the
// converter holds no number, so one number is converted at a time.
// Output request (m_*): one ASCII character per request, most significant digit
// first, a leading '-' for a negative signed decimal; m_tlast marks the final
// character of each number.
// Decimal numbers pass a shift-and-add-3 binary-to-BCD loop that takes one value
// bit per cycle, then leading zero digits are dropped one per cycle, then digits
// leave one per cycle, while the receiver is ready, from the same shift register.
// Hex and octal values load straight into that register and skip the BCD loop.
// A stalled receiver holds the current character in the output register and the
// converter waits; the next number is taken while the last character still waits.
// Reset empties the output register and returns the converter to idle.
`include "integer_to_ascii_radix_assert.svh"

module integer_to_ascii_radix
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [0] is_signed, [2:1] radix_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_out, [7] zero
    output logic        m_tlast    // last
);

    state_t state_reg, state_next;

    logic [SR_W-1:0]        sr_reg, sr_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   oct_reg, oct_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    // Decode of the incoming request.
    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [1:0]             in_radix;
    logic                   in_hex;
    logic                   in_oct;
    logic                   in_neg;
    logic                   accept;

    // Digit at the head of the shift register and the register after one digit.
    logic [3:0]      top_digit;
    logic [SR_W-1:0] sr_shifted;
    logic            out_free;
    logic            cnt_one;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_radix = s_tuser[2:1];
    assign in_hex   = (in_radix == RADIX_HEX);
    assign in_oct   = (in_radix == RADIX_OCT);
    // Sign only applies in decimal; the unused radix code also converts in decimal.
    assign in_neg   = !in_hex && !in_oct && s_tuser[0] && in_value[VALUE_WIDTH-1];
    // Two's complement negate gives the right magnitude for the most negative value.
    assign in_mag   = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign top_digit  = oct_reg ? {1'b0, sr_reg[SR_W-1 -: 3]} : sr_reg[SR_W-1 -: 4];
    assign sr_shifted = oct_reg ? (sr_reg << 3) : (sr_reg << 4);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cnt_one    = (cnt_reg == CNT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_hex || in_oct) ? ST_SKIP : ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit != 4'd0 || cnt_one)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && cnt_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        logic [DEC_BITS-1:0] bcd;
        logic [DEC_BITS-1:0] bcd_adj;

        sr_next       = sr_reg;
        bin_next      = bin_reg;
        bit_cnt_next  = bit_cnt_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        oct_next      = oct_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        // BCD digits sit at the head of the shift register during the loop.
        bcd = sr_reg[SR_W-1 -: DEC_BITS];
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3)
                                                        : bcd[i*4 +: 4];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = in_neg;
                    oct_next = in_oct;
                    bin_next = in_mag;
                    bit_cnt_next = BIT_W'(VALUE_WIDTH);
                    if (in_hex)
                    begin
                        sr_next  = SR_W'(in_mag) << (SR_W - HEX_BITS);
                        cnt_next = CNT_W'(HEX_DIGITS);
                    end
                    else if (in_oct)
                    begin
                        sr_next  = SR_W'(in_mag) << (SR_W - OCT_BITS);
                        cnt_next = CNT_W'(OCT_DIGITS);
                    end
                    else
                    begin
                        sr_next  = '0;
                        cnt_next = CNT_W'(DEC_DIGITS);
                    end
                end
            end
            ST_DABBLE:
            begin
                // Correct every digit, then shift in the next value bit.
                sr_next[SR_W-1 -: DEC_BITS] = {bcd_adj[DEC_BITS-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - BIT_W'(1);
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && !cnt_one)
                begin
                    sr_next  = sr_shifted;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    m_char_next   = CHAR_MINUS;
                    m_last_next   = 1'b0;
                    m_tvalid_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_char_next   = DIGIT_SET[top_digit];
                    m_last_next   = cnt_one;
                    m_tvalid_next = 1'b1;
                    sr_next       = sr_shifted;
                    cnt_next      = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            bit_cnt_reg  <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            bit_cnt_reg  <= bit_cnt_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg     <= sr_next;
        bin_reg    <= bin_next;
        neg_reg    <= neg_next;
        oct_reg    <= oct_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != ST_IDLE, "request taken but idle")
    `ASSERT_IMPL(a_dabble_cnt, clk, rst_n, state_reg == ST_DABBLE, bit_cnt_reg != '0, "BCD loop overrun")
    `ASSERT_IMPL(a_emit_cnt, clk, rst_n, state_reg == ST_EMIT, cnt_reg != '0, "digit count exhausted")
    `ASSERT_IMPL(a_minus_not_last, clk, rst_n, m_tvalid && (m_tdata[6:0] == CHAR_MINUS), !m_tlast, "minus marked last")

endmodule
